>>> hw/rtl/cda_pkg.sv
package cda_pkg;

  // Microprogram counter
  localparam int PcW = 4;
  typedef logic [PcW-1:0] pc_t;

  localparam logic [3:0] MonthsPerYear = 4'd12;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_LOAD       = 2'd0,
    OP_ADD_DAYS   = 2'd1,
    OP_ADD_MONTHS = 2'd2,
    OP_ADD_YEARS  = 2'd3
  } op_t;

  // Datapath operation of one control word
  typedef enum logic [3:0] {
    A_NOP    = 4'd0,
    A_LOAD   = 4'd1,
    A_DADD   = 4'd2,
    A_LEAPA  = 4'd3,
    A_LEAPB  = 4'd4,
    A_DSTEP  = 4'd5,
    A_MDIV   = 4'd6,
    A_MAPPLY = 4'd7,
    A_YADD   = 4'd8,
    A_PUB    = 4'd9
  } alu_t;

  // Sequencing of one control word
  typedef enum logic [1:0] {
    C_NEXT    = 2'd0,
    C_JMP     = 2'd1,
    C_DAYLOOP = 2'd2,
    C_DONE    = 2'd3
  } cond_t;

  typedef struct packed {
    alu_t  alu;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Sequencer to datapath
  typedef struct packed {
    logic capture;
    alu_t alu;
  } ctrl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic fits;
    logic dec;
  } stat_t;

  // Program addresses
  localparam pc_t S_LOAD  = 4'd0;
  localparam pc_t S_DADD  = 4'd1;
  localparam pc_t S_LEAP1 = 4'd2;
  localparam pc_t S_LEAP2 = 4'd3;
  localparam pc_t S_DLOOP = 4'd4;
  localparam pc_t S_RLEAP1 = 4'd5;
  localparam pc_t S_RLEAP2 = 4'd6;
  localparam pc_t S_MDIV  = 4'd7;
  localparam pc_t S_MAPPLY = 4'd8;
  localparam pc_t S_YADD  = 4'd9;
  localparam pc_t S_END   = 4'd10;

  // Control store
  function automatic uword_t urom(pc_t pc);
    uword_t w;
    unique case (pc)
      S_LOAD:   w = '{alu: A_LOAD,   cond: C_JMP,     target: S_END};
      S_DADD:   w = '{alu: A_DADD,   cond: C_NEXT,    target: S_END};
      S_LEAP1:  w = '{alu: A_LEAPA,  cond: C_NEXT,    target: S_END};
      S_LEAP2:  w = '{alu: A_LEAPB,  cond: C_NEXT,    target: S_END};
      S_DLOOP:  w = '{alu: A_DSTEP,  cond: C_DAYLOOP, target: S_END};
      S_RLEAP1: w = '{alu: A_LEAPA,  cond: C_NEXT,    target: S_END};
      S_RLEAP2: w = '{alu: A_LEAPB,  cond: C_JMP,     target: S_DLOOP};
      S_MDIV:   w = '{alu: A_MDIV,   cond: C_NEXT,    target: S_END};
      S_MAPPLY: w = '{alu: A_MAPPLY, cond: C_JMP,     target: S_END};
      S_YADD:   w = '{alu: A_YADD,   cond: C_JMP,     target: S_END};
      default:  w = '{alu: A_PUB,    cond: C_DONE,    target: S_END};
    endcase
    return w;
  endfunction

  // Entry point of each operation
  function automatic pc_t entry_of(op_t op);
    pc_t p;
    unique case (op)
      OP_LOAD:       p = S_LOAD;
      OP_ADD_DAYS:   p = S_DADD;
      OP_ADD_MONTHS: p = S_MDIV;
      OP_ADD_YEARS:  p = S_YADD;
      default:       p = S_END;
    endcase
    return p;
  endfunction

  // Month length; a month out of range counts as January
  function automatic logic [4:0] days_in(logic [3:0] m, logic leap);
    logic [4:0] d;
    case (m) inside
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

>>> hw/rtl/cda_if.sv
interface cda_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [15:0] load_year;
  logic [3:0]  load_month;
  logic [4:0]  load_day;
  logic [15:0] amount;

  modport source(output valid, output op, output load_year, output load_month,
                 output load_day, output amount, input ready);
  modport sink(input valid, input op, input load_year, input load_month,
               input load_day, input amount, output ready);
endinterface

interface cda_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] cur_year;
  logic [3:0]  cur_month;
  logic [4:0]  cur_day;
  logic        year_wrapped;

  modport source(output valid, output cur_year, output cur_month, output cur_day,
                 output year_wrapped, input ready);
  modport sink(input valid, input cur_year, input cur_month, input cur_day,
               input year_wrapped, output ready);
endinterface

>>> hw/rtl/cda_seq.sv
module cda_seq import cda_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  logic [1:0] cmd_op,
  output logic       cmd_ready,
  input  logic       res_ready,
  output logic       res_valid,
  input  stat_t      stat,
  output ctrl_t      ctrl
);

  logic   busy;
  pc_t    pc;
  pc_t    pc_next;
  uword_t uw;
  logic   take;
  logic   stall;
  logic   finish;

  assign uw        = urom(pc);
  assign cmd_ready = !busy;
  assign take      = cmd_valid && !busy;
  // hold the final step while the previous word still waits at the output
  assign stall     = busy && (uw.cond == C_DONE) && res_valid && !res_ready;
  assign finish    = busy && (uw.cond == C_DONE) && !stall;

  // pick the next step
  always_comb begin
    pc_next = pc_t'(pc + 1'b1);
    case (uw.cond)
      C_JMP: pc_next = uw.target;
      C_DAYLOOP: begin
        if (stat.fits) begin
          pc_next = uw.target;
        end else if (!stat.dec) begin
          pc_next = pc;
        end
      end
      default: ;
    endcase
  end

  assign ctrl.capture = take;
  assign ctrl.alu     = (busy && !stall) ? uw.alu : A_NOP;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pc        <= S_END;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        pc   <= entry_of(op_t'(cmd_op));
      end else if (busy && !stall) begin
        if (uw.cond == C_DONE) begin
          busy <= 1'b0;
        end else begin
          pc <= pc_next;
        end
      end
      // present the word, drop it once taken
      if (finish) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/cda_dpath.sv
module cda_dpath import cda_pkg::*; #(
  parameter int YEAR_BITS   = 16,
  parameter int AMOUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_t       ctrl,
  input  logic [15:0] load_year,
  input  logic [3:0]  load_month,
  input  logic [4:0]  load_day,
  input  logic [15:0] amount,
  output stat_t       stat,
  output logic [15:0] cur_year,
  output logic [3:0]  cur_month,
  output logic [4:0]  cur_day,
  output logic        year_wrapped
);

  localparam int AmtW = (AMOUNT_BITS < 16) ? AMOUNT_BITS : 16;
  localparam int SumW = ((YEAR_BITS > 16) ? YEAR_BITS : 16) + 1;

  // date state
  logic [YEAR_BITS-1:0] year_reg;
  logic [3:0]           month_reg;
  logic [16:0]          day_work;
  logic                 wrapped;
  logic                 leap;

  // captured word and scratch registers
  logic [AmtW-1:0] amt_q;
  logic [15:0]     ld_year;
  logic [3:0]      ld_month;
  logic [4:0]      ld_day;
  logic [13:0]     fold;
  logic [12:0]     quot;
  logic [16:0]     tot_q;

  // shared year adder
  logic [SumW-1:0]      yaddend;
  logic [SumW-1:0]      ysum;
  logic                 ycarry;
  logic [YEAR_BITS-1:0] year_new;

  always_comb begin
    case (ctrl.alu)
      A_MAPPLY: yaddend = SumW'(quot);
      A_YADD:   yaddend = SumW'(amt_q);
      default:  yaddend = SumW'(1);
    endcase
  end

  assign ysum     = SumW'(year_reg) + yaddend;
  assign ycarry   = |ysum[SumW-1:YEAR_BITS];
  assign year_new = ysum[YEAR_BITS-1:0];

  // month length and loop status
  logic [4:0] dim;
  assign dim       = days_in(month_reg, leap);
  assign stat.fits = day_work <= 17'(dim);
  assign stat.dec  = month_reg >= MonthsPerYear;

  // load clamping
  logic [3:0] ld_m_fix;
  logic [4:0] ld_d_fix;
  assign ld_m_fix = (ld_month == 4'd0) ? 4'd1 :
                    (ld_month > MonthsPerYear) ? MonthsPerYear : ld_month;
  assign ld_d_fix = (ld_day == 5'd0) ? 5'd1 : ld_day;

  // leap test, first fold: 256^k mod 25 is 1, 6, 11, 16
  logic [31:0] y32;
  logic [13:0] fold_next;
  assign y32       = 32'(year_reg);
  assign fold_next = 14'(y32[7:0]) + 14'(y32[15:8]) * 14'd6
                   + 14'(y32[23:16]) * 14'd11 + 14'(y32[31:24]) * 14'd16;

  // leap test, second fold and remainder by 25
  logic [8:0]  v2;
  logic [14:0] v2_prod;
  logic [4:0]  q25;
  logic [8:0]  r25;
  logic        leap_next;
  assign v2        = 9'(fold[7:0]) + 9'(fold[13:8]) * 9'd6;
  assign v2_prod   = 15'(v2) * 15'd41;
  assign q25       = v2_prod[14:10];
  assign r25       = v2 - 9'(q25) * 9'd25;
  assign leap_next = (y32[1:0] == 2'd0) && ((r25 != 9'd0) || (y32[3:0] == 4'd0));

  // months to add, split into years and month by twelve
  logic [16:0] total;
  logic [30:0] mprod;
  logic [16:0] rem;
  assign total = 17'(month_reg) - 17'd1 + 17'(amt_q);
  assign mprod = 31'(total[16:2]) * 31'(16'hAAAB);
  assign rem   = tot_q - ((17'(quot) << 3) + (17'(quot) << 2));

  // capture the incoming word
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      amt_q    <= amount[AmtW-1:0];
      ld_year  <= load_year;
      ld_month <= load_month;
      ld_day   <= load_day;
    end
  end

  // scratch results
  always_ff @(posedge clk) begin
    if (ctrl.alu == A_LEAPA) begin
      fold <= fold_next;
    end
    if (ctrl.alu == A_MDIV) begin
      quot  <= mprod[29:17];
      tot_q <= total;
    end
  end

  // date state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      year_reg  <= '0;
      month_reg <= 4'd1;
      day_work  <= 17'd1;
      wrapped   <= 1'b0;
      leap      <= 1'b1;
    end else begin
      if (ctrl.capture) begin
        wrapped <= 1'b0;
      end
      unique case (ctrl.alu)
        A_LOAD: begin
          year_reg  <= YEAR_BITS'(ld_year);
          month_reg <= ld_m_fix;
          day_work  <= 17'(ld_d_fix);
        end
        A_DADD: begin
          day_work <= day_work + 17'(amt_q);
        end
        A_LEAPB: begin
          leap <= leap_next;
        end
        A_DSTEP: begin
          if (!stat.fits) begin
            day_work <= day_work - 17'(dim);
            if (stat.dec) begin
              month_reg <= 4'd1;
              year_reg  <= year_new;
              wrapped   <= wrapped | ycarry;
            end else begin
              month_reg <= month_reg + 4'd1;
            end
          end
        end
        A_MAPPLY: begin
          month_reg <= rem[3:0] + 4'd1;
          year_reg  <= year_new;
          wrapped   <= ycarry;
        end
        A_YADD: begin
          year_reg <= year_new;
          wrapped  <= ycarry;
        end
        default: ;
      endcase
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (ctrl.alu == A_PUB) begin
      cur_year     <= 16'(year_reg);
      cur_month    <= month_reg;
      cur_day      <= day_work[4:0];
      year_wrapped <= wrapped;
    end
  end

endmodule

>>> hw/rtl/calendar_date_adder.sv
// Steps: load runs load, then publish; add years runs the year add, then publish;
// add months the month divide and month apply, then publish; add days the day add,
// leap test, month step loop (one month a cycle, leap retest per year crossed), then publish.
// One word in flight; the next is accepted the cycle after its result is registered.
// Synchronous active-high reset sets the date to year 0, month 1, day 1.
module calendar_date_adder import cda_pkg::*; #(
  parameter int YEAR_BITS   = 16,
  parameter int AMOUNT_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  cda_cmd_if.sink   cmd,
  cda_res_if.source res
);

  ctrl_t ctrl;
  stat_t stat;

  // step counter and control store
  cda_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_op    (cmd.op),
    .cmd_ready (cmd.ready),
    .res_ready (res.ready),
    .res_valid (res.valid),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // date registers and arithmetic
  cda_dpath #(
    .YEAR_BITS   (YEAR_BITS),
    .AMOUNT_BITS (AMOUNT_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .load_year    (cmd.load_year),
    .load_month   (cmd.load_month),
    .load_day     (cmd.load_day),
    .amount       (cmd.amount),
    .stat         (stat),
    .cur_year     (res.cur_year),
    .cur_month    (res.cur_month),
    .cur_day      (res.cur_day),
    .year_wrapped (res.year_wrapped)
  );

endmodule
